// File: rtl/core/apu_mix_dc_block_soft_clip_macros.svh
// assertion macros shared by the mixer rtl
`ifndef APU_MIX_DC_BLOCK_SOFT_CLIP_MACROS_SVH
`define APU_MIX_DC_BLOCK_SOFT_CLIP_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define APU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define APU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/apu_mix_pkg.sv
// types, constants and helpers for the mixer with dc blocker and soft clipper
package apu_mix_pkg;

	// mix weights, left plus right contribution per channel
	localparam int W_PULSE_ONE = 6 + 3;
	localparam int W_PULSE_TWO = 3 + 6;
	localparam int W_TRIANGLE = 5 + 5;
	localparam int W_NOISE = 51 + 51;
	localparam int W_DELTA = 80 + 80;
	localparam int W_EXPANSION = 18 + 18;

	localparam int LEVEL_W = 8;
	localparam int MIX_SUM_W = 17;
	localparam int MONO_W = 16;
	localparam int HP_W = 32;
	localparam int HP_SHIFT = 8;

	// configuration
	localparam int VOLUME_W = 7;
	localparam logic [VOLUME_W-1:0] VOLUME_RESET = 7'd100;
	localparam logic REG_VOLUME = 1'b0;

	// scaling by volume / 100, one decimal-ish digit of four bits per step
	localparam int VOL_SCALE = 100;
	localparam int DIV_STEPS = 10;
	localparam int DIV_MAG_W = DIV_STEPS * 4;
	localparam int DIV_REM_W = 7;
	localparam int DIV_WIN_W = DIV_REM_W + 4;
	localparam int QUOT_W = 32;
	localparam int OUT_GAIN_SH = 2;
	localparam int VMAG_W = QUOT_W + OUT_GAIN_SH;

	// soft clipper
	localparam int CLIP_KNEE = 22000;
	localparam int CLIP_LIMIT = 32767;
	localparam int CLIP_ROOM = CLIP_LIMIT - CLIP_KNEE;
	localparam int CLIP_STEPS = 14;
	localparam int OVER_W = 28;
	localparam int OVER_CAP = 2 ** (OVER_W - 1);
	localparam int NUM_W = OVER_W + CLIP_STEPS;
	localparam int MAG_W = 15;
	localparam int CNT_W = 4;

	typedef struct packed {
		logic [LEVEL_W-1:0] pulse_one;
		logic [LEVEL_W-1:0] pulse_two;
		logic [LEVEL_W-1:0] triangle_level;
		logic [LEVEL_W-1:0] noise_level;
		logic [LEVEL_W-1:0] delta_level;
		logic [LEVEL_W-1:0] expansion_level;
		logic batch_end;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic batch_end_out;
	} out_item_t;

	// filtered sample on its way from front to back
	typedef struct packed {
		logic signed [HP_W-1:0] hp;
		logic batch_end;
	} q_item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_KNEE,
		BK_NUM,
		BK_CLIP,
		BK_DONE
	} bk_state_t;

	// quotient digit of a window below 16 * 100 divided by 100
	function automatic logic [3:0] div100_digit(input logic [DIV_WIN_W-1:0] win);
		logic [3:0] d;
		d = '0;
		for (int k = 1; k < 16; k++) begin
			if (win >= DIV_WIN_W'(k * VOL_SCALE)) begin
				d = 4'(k);
			end
		end
		return d;
	endfunction

	// signed sample from sign and magnitude
	function automatic logic signed [15:0] apply_sign(input logic neg,
			input logic [MAG_W-1:0] mag);
		logic signed [15:0] s;
		s = $signed({1'b0, mag});
		return neg ? -s : s;
	endfunction

endpackage

// File: rtl/core/apu_mix_if.sv
// handshake channels for channel levels in and mono samples out

interface apu_mix_in_if;
	logic valid;
	logic ready;
	apu_mix_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface apu_mix_out_if;
	logic valid;
	logic ready;
	apu_mix_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/apu_mix_fifo.sv
// short queue of filtered samples between front and back
`include "apu_mix_dc_block_soft_clip_macros.svh"

module apu_mix_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  apu_mix_pkg::q_item_t  push_data,
	output logic                  full,
	input  logic                  pop,
	output apu_mix_pkg::q_item_t  pop_data,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	apu_mix_pkg::q_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`APU_ASSERT_IMP(a_no_overflow, push, !full, "queue written while full")
	`APU_ASSERT_IMP(a_no_underflow, pop, !empty, "queue read while empty")

endmodule

// File: rtl/core/apu_mix_front.sv
// front end: mixes the levels to mono and runs the dc blocker
module apu_mix_front (
	input  logic                  clk,
	input  logic                  arst_n,
	apu_mix_in_if.sink            levels,
	output logic                  push,
	output apu_mix_pkg::q_item_t  push_data,
	input  logic                  full
);

	logic s1_valid_q;
	logic [apu_mix_pkg::MONO_W-1:0] mono_s1;
	logic batch_s1;
	logic [apu_mix_pkg::MONO_W-1:0] prev_mono_q;
	logic signed [apu_mix_pkg::HP_W-1:0] prev_hp_q;
	logic [apu_mix_pkg::MIX_SUM_W-1:0] mix_sum;
	logic signed [apu_mix_pkg::HP_W-1:0] hp_tail;
	logic signed [apu_mix_pkg::HP_W-1:0] hp;
	logic take;

	// weighted mix of all six channels
	assign mix_sum =
		apu_mix_pkg::MIX_SUM_W'(apu_mix_pkg::W_PULSE_ONE) *
			apu_mix_pkg::MIX_SUM_W'(levels.data.pulse_one) +
		apu_mix_pkg::MIX_SUM_W'(apu_mix_pkg::W_PULSE_TWO) *
			apu_mix_pkg::MIX_SUM_W'(levels.data.pulse_two) +
		apu_mix_pkg::MIX_SUM_W'(apu_mix_pkg::W_TRIANGLE) *
			apu_mix_pkg::MIX_SUM_W'(levels.data.triangle_level) +
		apu_mix_pkg::MIX_SUM_W'(apu_mix_pkg::W_NOISE) *
			apu_mix_pkg::MIX_SUM_W'(levels.data.noise_level) +
		apu_mix_pkg::MIX_SUM_W'(apu_mix_pkg::W_DELTA) *
			apu_mix_pkg::MIX_SUM_W'(levels.data.delta_level) +
		apu_mix_pkg::MIX_SUM_W'(apu_mix_pkg::W_EXPANSION) *
			apu_mix_pkg::MIX_SUM_W'(levels.data.expansion_level);

	// handshake: stage one moves on when the queue has room
	assign push = s1_valid_q && !full;
	assign levels.ready = !s1_valid_q || !full;
	assign take = levels.valid && levels.ready;

	// one-pole dc blocker, wraps at 32 bits
	assign hp_tail = prev_hp_q >>> apu_mix_pkg::HP_SHIFT;
	assign hp = prev_hp_q - hp_tail
		+ $signed(apu_mix_pkg::HP_W'(mono_s1))
		- $signed(apu_mix_pkg::HP_W'(prev_mono_q));

	assign push_data.hp = hp;
	assign push_data.batch_end = batch_s1;

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
		end else if (push) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage one payload: folded mono sample
	always_ff @(posedge clk) begin
		if (take) begin
			mono_s1 <= mix_sum[apu_mix_pkg::MIX_SUM_W-1:1];
			batch_s1 <= levels.data.batch_end;
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mono_q <= '0;
			prev_hp_q <= '0;
		end else if (push) begin
			prev_mono_q <= mono_s1;
			prev_hp_q <= hp;
		end
	end

endmodule

// File: rtl/core/apu_mix_back.sv
// back end: volume scaling, gain and soft clipping, one item at a time
`include "apu_mix_dc_block_soft_clip_macros.svh"

module apu_mix_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [apu_mix_pkg::VOLUME_W-1:0]      volume,
	input  logic                                  q_empty,
	input  apu_mix_pkg::q_item_t                  q_data,
	output logic                                  pop,
	apu_mix_out_if.source                         sample
);

	apu_mix_pkg::bk_state_t state_q;
	apu_mix_pkg::bk_state_t state_d;

	logic signed [apu_mix_pkg::HP_W-1:0] hp_q;
	logic batch_q;
	logic neg_q;
	logic [apu_mix_pkg::DIV_MAG_W-1:0] mag_q;
	logic [apu_mix_pkg::DIV_REM_W-1:0] rem_q;
	logic [apu_mix_pkg::QUOT_W-1:0] quot_q;
	logic [apu_mix_pkg::CNT_W-1:0] cnt_q;
	logic [apu_mix_pkg::OVER_W-1:0] over_q;
	logic [apu_mix_pkg::NUM_W-1:0] num_q;
	logic [apu_mix_pkg::NUM_W-1:0] den_q;
	logic [apu_mix_pkg::CLIP_STEPS-1:0] cq_q;
	logic signed [15:0] res_q;
	logic out_valid_q;
	apu_mix_pkg::out_item_t out_data_q;

	logic signed [apu_mix_pkg::DIV_MAG_W-1:0] prod;
	logic [apu_mix_pkg::DIV_WIN_W-1:0] win;
	logic [3:0] digit;
	logic [apu_mix_pkg::VMAG_W-1:0] vmag;
	logic [apu_mix_pkg::VMAG_W-1:0] over;
	logic over_knee;
	logic num_ge;
	logic [apu_mix_pkg::CLIP_STEPS-1:0] cq_next;
	logic div_last;
	logic clip_last;
	logic out_free;
	logic load_out;

	// scale product, sign taken apart below
	assign prod = $signed(apu_mix_pkg::DIV_MAG_W'(hp_q))
		* $signed(apu_mix_pkg::DIV_MAG_W'({1'b0, volume}));

	// divide by 100, four bits of the magnitude per step
	assign win = {rem_q, mag_q[apu_mix_pkg::DIV_MAG_W-1 -: 4]};
	assign digit = apu_mix_pkg::div100_digit(win);

	// gain and knee check
	assign vmag = apu_mix_pkg::VMAG_W'(quot_q) << apu_mix_pkg::OUT_GAIN_SH;
	assign over_knee = vmag > apu_mix_pkg::VMAG_W'(apu_mix_pkg::CLIP_KNEE);
	assign over = vmag - apu_mix_pkg::VMAG_W'(apu_mix_pkg::CLIP_KNEE);

	// clip divider, one quotient bit per step
	assign num_ge = num_q >= den_q;
	assign cq_next = {cq_q[apu_mix_pkg::CLIP_STEPS-2:0], num_ge};

	assign div_last = cnt_q == apu_mix_pkg::CNT_W'(apu_mix_pkg::DIV_STEPS - 1);
	assign clip_last = cnt_q == apu_mix_pkg::CNT_W'(apu_mix_pkg::CLIP_STEPS - 1);
	assign out_free = !out_valid_q || sample.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			apu_mix_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = (volume == '0) ? apu_mix_pkg::BK_DONE : apu_mix_pkg::BK_MUL;
				end
			end
			apu_mix_pkg::BK_MUL: begin
				state_d = apu_mix_pkg::BK_DIV;
			end
			apu_mix_pkg::BK_DIV: begin
				if (div_last) begin
					state_d = apu_mix_pkg::BK_KNEE;
				end
			end
			apu_mix_pkg::BK_KNEE: begin
				state_d = over_knee ? apu_mix_pkg::BK_NUM : apu_mix_pkg::BK_DONE;
			end
			apu_mix_pkg::BK_NUM: begin
				state_d = apu_mix_pkg::BK_CLIP;
			end
			apu_mix_pkg::BK_CLIP: begin
				if (clip_last) begin
					state_d = apu_mix_pkg::BK_DONE;
				end
			end
			apu_mix_pkg::BK_DONE: begin
				if (out_free) begin
					state_d = apu_mix_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = apu_mix_pkg::BK_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		pop = 1'b0;
		load_out = 1'b0;
		case (state_q)
			apu_mix_pkg::BK_IDLE: begin
				pop = !q_empty;
			end
			apu_mix_pkg::BK_DONE: begin
				load_out = out_free;
			end
			default: begin
				pop = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apu_mix_pkg::BK_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == apu_mix_pkg::BK_DIV || state_q == apu_mix_pkg::BK_CLIP) begin
				cnt_q <= (div_last || clip_last) && state_q == state_d ? cnt_q + 1'b1 :
					((state_q != state_d) ? '0 : cnt_q + 1'b1);
			end else begin
				cnt_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (sample.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			apu_mix_pkg::BK_IDLE: begin
				hp_q <= q_data.hp;
				batch_q <= q_data.batch_end;
				res_q <= '0;
			end
			apu_mix_pkg::BK_MUL: begin
				neg_q <= prod[apu_mix_pkg::DIV_MAG_W-1];
				mag_q <= prod[apu_mix_pkg::DIV_MAG_W-1] ? apu_mix_pkg::DIV_MAG_W'(-prod)
					: apu_mix_pkg::DIV_MAG_W'(prod);
				rem_q <= '0;
				quot_q <= '0;
			end
			apu_mix_pkg::BK_DIV: begin
				rem_q <= apu_mix_pkg::DIV_REM_W'(win
					- apu_mix_pkg::DIV_WIN_W'(digit)
					* apu_mix_pkg::DIV_WIN_W'(apu_mix_pkg::VOL_SCALE));
				mag_q <= mag_q << 4;
				quot_q <= {quot_q[apu_mix_pkg::QUOT_W-5:0], digit};
			end
			apu_mix_pkg::BK_KNEE: begin
				res_q <= apu_mix_pkg::apply_sign(neg_q, vmag[apu_mix_pkg::MAG_W-1:0]);
				// far past the knee the quotient no longer changes
				over_q <= (over >= apu_mix_pkg::VMAG_W'(apu_mix_pkg::OVER_CAP))
					? apu_mix_pkg::OVER_W'(apu_mix_pkg::OVER_CAP)
					: over[apu_mix_pkg::OVER_W-1:0];
			end
			apu_mix_pkg::BK_NUM: begin
				num_q <= apu_mix_pkg::NUM_W'(over_q)
					* apu_mix_pkg::NUM_W'(apu_mix_pkg::CLIP_ROOM);
				den_q <= (apu_mix_pkg::NUM_W'(over_q)
					+ apu_mix_pkg::NUM_W'(apu_mix_pkg::CLIP_ROOM))
					<< (apu_mix_pkg::CLIP_STEPS - 1);
				cq_q <= '0;
			end
			apu_mix_pkg::BK_CLIP: begin
				if (num_ge) begin
					num_q <= num_q - den_q;
				end
				den_q <= den_q >> 1;
				cq_q <= cq_next;
				res_q <= apu_mix_pkg::apply_sign(neg_q,
					apu_mix_pkg::MAG_W'(apu_mix_pkg::CLIP_KNEE)
					+ apu_mix_pkg::MAG_W'(cq_next));
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q.sample_out <= res_q;
			out_data_q.batch_end_out <= batch_q;
		end
	end

	assign sample.valid = out_valid_q;
	assign sample.data = out_data_q;

	`APU_ASSERT_IMP(a_pop_in_idle, pop, state_q == apu_mix_pkg::BK_IDLE, "queue read while busy")
	`APU_ASSERT_IMP(a_clip_count, state_q == apu_mix_pkg::BK_CLIP, cnt_q < apu_mix_pkg::CNT_W'(apu_mix_pkg::CLIP_STEPS), "clip divider overran")
	`APU_ASSERT_IMP(a_out_range, out_valid_q, !out_data_q.sample_out[15] || out_data_q.sample_out[14:0] != '0, "sample outside clip range")
	`APU_ASSERT_NXT(a_load_leaves_done, load_out, state_q == apu_mix_pkg::BK_IDLE, "sequencer stuck after result")

endmodule

// File: rtl/core/apu_mix_dc_block_soft_clip.sv
// top level: six-channel mixer with dc blocker, volume and soft clipper
//
// levels carries one item per sample: six unsigned 8-bit channel levels and a
// batch end marker. sample returns one signed 16-bit mono sample per item,
// always within +-32767, with the marker copied through, in input order.
// volume_percent sits at byte address 0 of the apb port; 0 mutes the output
// while the dc blocker keeps tracking the input.
// the front mixes an item into a stage register and filters it into the queue.
// it can take one item per cycle while the queue has room. the back handles one
// item at a time: when muted it goes from idle straight to done; below the knee
// it runs the divide-by-100 digit loop (10 steps) and the knee check; above it,
// it also runs the bit-serial clip divider (14 steps).
// reset clears the filter history, empties the queue and output register and
// sets the volume to 100. when the receiver stalls, the result holds in the
// output register, the back waits with the next result, the queue fills and
// then levels drops ready.
module apu_mix_dc_block_soft_clip #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	apu_mix_in_if.sink   levels,
	apu_mix_out_if.source sample,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [apu_mix_pkg::VOLUME_W-1:0] volume_q;
	logic push;
	logic pop;
	logic full;
	logic empty;
	apu_mix_pkg::q_item_t push_data;
	apu_mix_pkg::q_item_t pop_data;

	// register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == apu_mix_pkg::REG_VOLUME) ? 32'(volume_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= apu_mix_pkg::VOLUME_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == apu_mix_pkg::REG_VOLUME) begin
			volume_q <= pwdata[apu_mix_pkg::VOLUME_W-1:0];
		end
	end

	apu_mix_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.levels    (levels),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	apu_mix_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	apu_mix_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.volume  (volume_q),
		.q_empty (empty),
		.q_data  (pop_data),
		.pop     (pop),
		.sample  (sample)
	);

endmodule

// File: tb/testbench.sv
// self-checking testbench for the six-channel mixer with dc blocker and soft clipper

// mix, filter, scale and clip predictor with a queue of expected mono samples
class mono_sample_tracker;
	logic [apu_mix_pkg::VOLUME_W-1:0] volume;
	longint prev_mono;
	longint prev_hp;
	apu_mix_pkg::out_item_t expected_samples[$];
	int failures;
	int reported;
	int checked;

	function new();
		volume = apu_mix_pkg::VOLUME_RESET;
		prev_mono = 0;
		prev_hp = 0;
		failures = 0;
		reported = 0;
		checked = 0;
	endfunction

	// mix, dc block, scale and clip one item of levels
	function apu_mix_pkg::out_item_t predict_sample(apu_mix_pkg::in_item_t it);
		longint mono, hp, v, mag, over;
		logic neg;
		apu_mix_pkg::out_item_t r;
		mono = (apu_mix_pkg::W_PULSE_ONE * longint'(it.pulse_one)
			+ apu_mix_pkg::W_PULSE_TWO * longint'(it.pulse_two)
			+ apu_mix_pkg::W_TRIANGLE * longint'(it.triangle_level)
			+ apu_mix_pkg::W_NOISE * longint'(it.noise_level)
			+ apu_mix_pkg::W_DELTA * longint'(it.delta_level)
			+ apu_mix_pkg::W_EXPANSION * longint'(it.expansion_level)) >>> 1;
		hp = mono - prev_mono + prev_hp - (prev_hp >>> apu_mix_pkg::HP_SHIFT);
		// filter state wraps at 32 bits
		hp = longint'(int'(hp));
		prev_mono = mono & 64'hFFFF;
		prev_hp = hp;
		v = 0;
		if (volume != 0) begin
			v = ((hp * longint'(volume)) / apu_mix_pkg::VOL_SCALE)
				* (1 << apu_mix_pkg::OUT_GAIN_SH);
			neg = v < 0;
			mag = neg ? -v : v;
			// soft knee above the linear range
			if (mag > apu_mix_pkg::CLIP_KNEE) begin
				over = mag - apu_mix_pkg::CLIP_KNEE;
				mag = apu_mix_pkg::CLIP_KNEE
					+ (over * apu_mix_pkg::CLIP_ROOM) / (over + apu_mix_pkg::CLIP_ROOM);
			end
			v = neg ? -mag : mag;
		end
		r.sample_out = 16'(v);
		r.batch_end_out = it.batch_end;
		return r;
	endfunction

	function void note_levels(apu_mix_pkg::in_item_t it);
		expected_samples.push_back(predict_sample(it));
	endfunction

	function void check_sample(apu_mix_pkg::out_item_t got);
		apu_mix_pkg::out_item_t want;
		checked++;
		if (expected_samples.size() == 0) begin
			failures++;
			if (reported < 10) begin
				reported++;
				$display("error: sample %0d arrived with none expected (sample %0d end %0b)",
					checked, got.sample_out, got.batch_end_out);
			end
			return;
		end
		want = expected_samples.pop_front();
		if (got.sample_out !== want.sample_out || got.batch_end_out !== want.batch_end_out) begin
			failures++;
			if (reported < 10) begin
				reported++;
				$display("error: sample %0d expected sample %0d end %0b, got sample %0d end %0b",
					checked, want.sample_out, want.batch_end_out,
					got.sample_out, got.batch_end_out);
			end
		end
	endfunction

	function int pending();
		return expected_samples.size();
	endfunction
endclass

module testbench;

	typedef enum int {
		PAT_NOISE,
		PAT_HOLD,
		PAT_SQUARE,
		PAT_QUIET,
		PAT_SOLO
	} pattern_t;

	localparam int SETTLE_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// idling switches for sender and receiver
	bit tx_gaps;
	bit rx_stalls;
	bit rx_started;

	mono_sample_tracker tracker;

	apu_mix_in_if levels_if();
	apu_mix_out_if sample_if();

	apu_mix_dc_block_soft_clip u_top (
		.clk(clk),
		.arst_n(arst_n),
		.levels(levels_if),
		.sample(sample_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// overall time limit
	initial begin
		#6000000;
		$display("apu_mix_dc_block_soft_clip test failed");
		$finish;
	end

	// observe both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (levels_if.valid && levels_if.ready) begin
				tracker.note_levels(levels_if.data);
			end
			if (sample_if.valid && sample_if.ready) begin
				tracker.check_sample(sample_if.data);
			end
		end
	end

	// receiver with random stall bursts
	always @(negedge clk) begin
		if (rx_started) begin
			if (rx_stalls && $urandom_range(0, 4) == 0) begin
				sample_if.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			sample_if.ready <= 1'b1;
		end else begin
			sample_if.ready <= 1'b0;
		end
	end

	function automatic apu_mix_pkg::in_item_t lv(input logic [7:0] p1, p2, tr, nz, dm, ex,
			input logic be);
		apu_mix_pkg::in_item_t it;
		it.pulse_one = p1;
		it.pulse_two = p2;
		it.triangle_level = tr;
		it.noise_level = nz;
		it.delta_level = dm;
		it.expansion_level = ex;
		it.batch_end = be;
		return it;
	endfunction

	function automatic apu_mix_pkg::in_item_t random_levels(input bit quiet);
		apu_mix_pkg::in_item_t it;
		int top;
		top = quiet ? 15 : 255;
		it.pulse_one = 8'($urandom_range(0, top));
		it.pulse_two = 8'($urandom_range(0, top));
		it.triangle_level = 8'($urandom_range(0, top));
		it.noise_level = 8'($urandom_range(0, top));
		it.delta_level = 8'($urandom_range(0, top));
		it.expansion_level = 8'($urandom_range(0, top));
		it.batch_end = ($urandom_range(0, 7) == 0);
		return it;
	endfunction

	// offer one item of levels, returns at the falling edge after acceptance
	task automatic push_levels(input apu_mix_pkg::in_item_t it);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			levels_if.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		levels_if.valid <= 1'b1;
		levels_if.data <= it;
		do @(posedge clk); while (!levels_if.ready);
		@(negedge clk);
	endtask

	// wait for every expected sample, then let the block settle
	task automatic wait_drained();
		levels_if.valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// apb write of the volume register while the block is idle
	task automatic write_volume(input logic [apu_mix_pkg::VOLUME_W-1:0] v);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {apu_mix_pkg::REG_VOLUME, 2'b00};
		pwdata <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.volume = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// random runs: noise, held levels, square waves, quiet levels, single channels
	task automatic run_random(input int count);
		int left, run_len;
		pattern_t pat;
		apu_mix_pkg::in_item_t a, b, it;
		logic [5:0] keep;
		left = count;
		while (left > 0) begin
			pat = pattern_t'($urandom_range(0, 4));
			run_len = $urandom_range(1, 20);
			a = random_levels(1'b0);
			b = random_levels(1'($urandom_range(0, 1)));
			keep = 6'b1 << $urandom_range(0, 5);
			for (int k = 0; k < run_len && left > 0; k++) begin
				case (pat)
					PAT_NOISE: it = random_levels(1'b0);
					PAT_HOLD: it = a;
					PAT_SQUARE: it = k[0] ? b : a;
					PAT_QUIET: it = random_levels(1'b1);
					default: begin
						it = lv(keep[0] ? a.pulse_one : 8'd0, keep[1] ? a.pulse_two : 8'd0,
							keep[2] ? a.triangle_level : 8'd0,
							keep[3] ? a.noise_level : 8'd0,
							keep[4] ? a.delta_level : 8'd0,
							keep[5] ? a.expansion_level : 8'd0, 1'b0);
						a = random_levels(1'b0);
					end
				endcase
				it.batch_end = ($urandom_range(0, 7) == 0);
				push_levels(it);
				left--;
			end
		end
	endtask

	// main sequence
	initial begin
		tracker = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		levels_if.valid = 1'b0;
		levels_if.data = '0;
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		rx_started = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		rx_started = 1'b1;

		// reset volume: silence, full step up and down, each channel alone
		push_levels(lv(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		push_levels(lv(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
		push_levels(lv(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
		push_levels(lv(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		push_levels(lv(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		push_levels(lv(8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		push_levels(lv(8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0));
		push_levels(lv(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 1'b1));
		push_levels(lv(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0));
		push_levels(lv(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b1));
		push_levels(lv(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 1'b0));

		// muted, filter state keeps moving
		write_volume(7'd0);
		push_levels(lv(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
		push_levels(lv(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
		push_levels(lv(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0));

		// volume above range, clipper bounds the amplified sample
		write_volume(7'd127);
		push_levels(lv(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		push_levels(lv(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
		push_levels(lv(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		push_levels(lv(8'd3, 8'd0, 8'd2, 8'd0, 8'd1, 8'd0, 1'b0));

		// lowest audible volume
		write_volume(7'd1);
		push_levels(lv(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
		push_levels(lv(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
		push_levels(lv(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));

		// random phases across volume settings
		write_volume(7'd100);
		run_random(150);
		write_volume(7'd0);
		run_random(100);
		write_volume(7'd127);
		run_random(150);
		write_volume(7'd1);
		run_random(100);
		for (int p = 0; p < 5; p++) begin
			write_volume(7'($urandom_range(0, 127)));
			run_random(130);
		end
		write_volume(7'($urandom_range(50, 100)));
		run_random(120);

		// closing stretch without idling on either side
		write_volume(7'd100);
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		run_random(130);

		wait_drained();
		if (tracker.failures == 0 && tracker.pending() == 0) begin
			$display("apu_mix_dc_block_soft_clip test passed");
		end else begin
			$display("apu_mix_dc_block_soft_clip test failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/apu_mix_pkg.sv
rtl/core/apu_mix_if.sv
rtl/core/apu_mix_fifo.sv
rtl/core/apu_mix_front.sv
rtl/core/apu_mix_back.sv
rtl/core/apu_mix_dc_block_soft_clip.sv
tb/testbench.sv
